>>> rtl/adt_pkg.sv
`default_nettype none

package adt_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = 5;
    localparam int COUNT_W     = 6;
    localparam logic [7:0] SIGHT_MAX = 8'hFF;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;

    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_SCAN  = 3'd3,
        ST_READ_OK   = 3'd4,
        ST_READ_OOR  = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0] appearance;
        logic [7:0]  sightings;
        logic [1:0]  address_kind;
        logic [7:0]  signal_dbm;
        logic [47:0] address;
    } entry_t;

    typedef struct packed {
        logic [7:0]  read_index;
        logic [15:0] appearance_code;
        logic        has_appearance;
        logic [1:0]  address_kind;
        logic [7:0]  signal_dbm;
        logic [47:0] adv_address;
        logic [1:0]  kind;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot_index;
        logic [COUNT_W-1:0]  fill_count;
        entry_t              entry;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/advertiser_dedup_table.sv
// Advertiser duplicate-filter table, 32 slots keyed by 48-bit address.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the command kind
// (report, read by index, clear), s_tdata the report fields and read index.
// Each input word gives exactly one result word on m_tvalid/m_tready, with
// the status code in m_tuser and the slot contents in m_tdata.
// The scan enable bit is written on cfg_valid/cfg_ready; the user must write
// it only while idle, as the block itself does not enforce that.
// A clear, or a report with scanning off, passes DECODE and DONE; a read
// passes DECODE, RDWAIT and DONE. A report with scanning on walks the used
// slots through one compare unit, one slot per cycle behind a registered
// memory read, and stops early on a match. s_tready returns with the result.
// A finished result sits in the output register; the next input word is
// accepted while it waits, and that word's result is held back until the
// receiver takes the earlier one, so a stalled receiver stalls the input
// after one word.
// Reset empties the table (fill count 0), clears scan enable and drops any
// pending result. Slot contents are not cleared and are never shown before
// they are written.
`default_nettype none

module advertiser_dedup_table (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // adv_address, signal_dbm, address_kind, has_appearance,
    // appearance_code, read_index
    input  wire logic [adt_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // slot_index, fill_count, entry_address, entry_signal,
    // entry_address_kind, entry_sightings, entry_appearance
    output logic [adt_pkg::M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [2:0]                          m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data
);

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        SCAN,
        RDWAIT,
        DONE
    } state_t;

    localparam int RES_W = adt_pkg::SLOT_W + adt_pkg::COUNT_W + $bits(adt_pkg::entry_t);

    state_t                           state_reg, state_next;
    adt_pkg::item_t                   item_reg, item_next;
    adt_pkg::result_t                 res_reg, res_next;
    adt_pkg::result_t                 m_res_reg, m_res_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [adt_pkg::COUNT_W-1:0]      used_reg, used_next;
    logic [adt_pkg::COUNT_W-1:0]      issue_reg, issue_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic [adt_pkg::SLOT_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                             rd_hit_reg, rd_hit_next;
    logic                             scan_en_reg;

    adt_pkg::entry_t                  mem [adt_pkg::TABLE_SLOTS];
    adt_pkg::entry_t                  rd_data_reg;
    logic                             rd_en;
    logic [adt_pkg::SLOT_W-1:0]       rd_addr;
    logic                             wr_en;
    logic [adt_pkg::SLOT_W-1:0]       wr_addr;
    adt_pkg::entry_t                  wr_data;

    logic                             out_free;
    logic                             issue_more;
    logic                             hit;
    adt_pkg::entry_t                  upd_entry;
    adt_pkg::entry_t                  new_entry;

    assign s_tready  = (state_reg == IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_res_reg.status;
    assign m_tdata   = {{(adt_pkg::M_TDATA_W - RES_W){1'b0}},
                        m_res_reg.entry.appearance,
                        m_res_reg.entry.sightings,
                        m_res_reg.entry.address_kind,
                        m_res_reg.entry.signal_dbm,
                        m_res_reg.entry.address,
                        m_res_reg.fill_count,
                        m_res_reg.slot_index};

    assign out_free   = !m_tvalid_reg || m_tready;
    assign issue_more = (issue_reg < used_reg);
    assign hit        = cmp_vld_reg && (rd_data_reg.address == item_reg.adv_address);

    always_comb begin
        upd_entry            = rd_data_reg;
        upd_entry.signal_dbm = item_reg.signal_dbm;
        upd_entry.sightings  = (rd_data_reg.sightings == adt_pkg::SIGHT_MAX) ?
                               rd_data_reg.sightings : rd_data_reg.sightings + 8'd1;
        new_entry.address      = item_reg.adv_address;
        new_entry.signal_dbm   = item_reg.signal_dbm;
        new_entry.address_kind = item_reg.address_kind;
        new_entry.sightings    = 8'd1;
        new_entry.appearance   = item_reg.has_appearance ? item_reg.appearance_code : 16'd0;
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        m_res_next    = m_res_reg;
        m_tvalid_next = m_tvalid_reg;
        used_next     = used_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        rd_hit_next   = rd_hit_reg;
        rd_en         = 1'b0;
        rd_addr       = issue_reg[adt_pkg::SLOT_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = cmp_idx_reg;
        wr_data       = upd_entry;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    item_next.kind            = s_tuser;
                    item_next.adv_address     = s_tdata[47:0];
                    item_next.signal_dbm      = s_tdata[55:48];
                    item_next.address_kind    = s_tdata[57:56];
                    item_next.has_appearance  = s_tdata[58];
                    item_next.appearance_code = s_tdata[74:59];
                    item_next.read_index      = s_tdata[82:75];
                    state_next                = DECODE;
                end
            end
            DECODE: begin
                res_next.slot_index = '0;
                res_next.fill_count = used_reg;
                res_next.entry      = '0;
                if (item_reg.kind[1]) begin
                    used_next           = '0;
                    res_next.status     = adt_pkg::ST_CLEARED;
                    res_next.fill_count = '0;
                    state_next          = DONE;
                end else if (item_reg.kind == adt_pkg::KIND_READ) begin
                    rd_hit_next = ({2'b00, used_reg} > item_reg.read_index);
                    rd_en       = rd_hit_next;
                    rd_addr     = item_reg.read_index[adt_pkg::SLOT_W-1:0];
                    state_next  = RDWAIT;
                end else if (!scan_en_reg) begin
                    res_next.status = adt_pkg::ST_NOT_SCAN;
                    state_next      = DONE;
                end else begin
                    issue_next   = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = SCAN;
                end
            end
            SCAN: begin
                // read one slot per cycle, compare the slot read the cycle before
                rd_en        = issue_more;
                issue_next   = issue_more ? issue_reg + 1'b1 : issue_reg;
                cmp_vld_next = issue_more;
                cmp_idx_next = issue_reg[adt_pkg::SLOT_W-1:0];
                if (hit) begin
                    wr_en               = 1'b1;
                    wr_addr             = cmp_idx_reg;
                    wr_data             = upd_entry;
                    res_next.status     = adt_pkg::ST_UPDATED;
                    res_next.slot_index = cmp_idx_reg;
                    res_next.fill_count = used_reg;
                    res_next.entry      = upd_entry;
                    state_next          = DONE;
                end else if (!cmp_vld_reg && !issue_more) begin
                    if (used_reg == adt_pkg::COUNT_W'(adt_pkg::TABLE_SLOTS)) begin
                        res_next.status     = adt_pkg::ST_FULL;
                        res_next.slot_index = '0;
                        res_next.fill_count = used_reg;
                        res_next.entry      = '0;
                    end else begin
                        wr_en               = 1'b1;
                        wr_addr             = used_reg[adt_pkg::SLOT_W-1:0];
                        wr_data             = new_entry;
                        used_next           = used_reg + 1'b1;
                        res_next.status     = adt_pkg::ST_INSERTED;
                        res_next.slot_index = used_reg[adt_pkg::SLOT_W-1:0];
                        res_next.fill_count = used_reg + 1'b1;
                        res_next.entry      = new_entry;
                    end
                    state_next = DONE;
                end
            end
            RDWAIT: begin
                res_next.fill_count = used_reg;
                if (rd_hit_reg) begin
                    res_next.status     = adt_pkg::ST_READ_OK;
                    res_next.slot_index = item_reg.read_index[adt_pkg::SLOT_W-1:0];
                    res_next.entry      = rd_data_reg;
                end else begin
                    res_next.status     = adt_pkg::ST_READ_OOR;
                    res_next.slot_index = '0;
                    res_next.entry      = '0;
                end
                state_next = DONE;
            end
            DONE: begin
                if (out_free) begin
                    m_res_next    = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
            used_reg     <= '0;
            issue_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            rd_hit_reg   <= 1'b0;
            scan_en_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            used_reg     <= used_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            rd_hit_reg   <= rd_hit_next;
            if (cfg_valid && cfg_ready) begin
                scan_en_reg <= cfg_data;
            end
        end
        item_reg    <= item_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    // slot table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= adt_pkg::COUNT_W'(adt_pkg::TABLE_SLOTS))
        else $error("fill count beyond table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    a_insert_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.status == adt_pkg::ST_INSERTED |->
        m_res_reg.fill_count == {1'b0, m_res_reg.slot_index} + 1'b1)
        else $error("inserted slot is not the last used slot");

    a_sightings_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_res_reg.status == adt_pkg::ST_UPDATED ||
                         m_res_reg.status == adt_pkg::ST_INSERTED) |->
        m_res_reg.entry.sightings != 8'd0)
        else $error("touched slot with zero sightings");

    a_scan_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg && state_reg == SCAN |-> {1'b0, cmp_idx_reg} < used_reg)
        else $error("compare on a slot beyond the fill count");

endmodule

`default_nettype wire
